/* hw/rtl/bls_pkg.sv */
// bls_pkg: shared codes, character constants and helpers for the bracketed list splitter
// no dependencies; compiled first

package bls_pkg;

  localparam int unsigned MAX_DEPTH   = 255;
  localparam int unsigned MAX_ENTRIES = 65535;

  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned COUNT_W = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_CAP =
    (MAX_DEPTH < 255) ? DEPTH_W'(MAX_DEPTH) : DEPTH_W'(255);
  localparam logic [COUNT_W-1:0] ENTRY_CAP =
    (MAX_ENTRIES > 65535) ? COUNT_W'(65535) : COUNT_W'(MAX_ENTRIES);

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [2:0] {
    ROLE_SPACE   = 3'd0,
    ROLE_OPEN    = 3'd1,
    ROLE_ENTRY   = 3'd2,
    ROLE_SEP     = 3'd3,
    ROLE_CLOSE   = 3'd4,
    ROLE_INVALID = 3'd5
  } role_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNABLE = 2'd1,
    ST_DOMAIN = 2'd2
  } status_t;

  typedef enum logic {
    REG_RESIZE_MODE    = 1'b0,
    REG_EXPECTED_COUNT = 1'b1
  } reg_idx_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
  endfunction

  function automatic logic is_opener(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
  endfunction

  function automatic logic is_closer(input logic [7:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
  endfunction

endpackage

/* hw/rtl/bls_in_if.sv */
// bls_in_if: request channel carrying text bytes into the splitter
// no dependencies

interface bls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_final;

  modport source (output valid, output text_byte, output is_final, input ready);
  modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

/* hw/rtl/bls_out_if.sv */
// bls_out_if: result channel carrying per-byte tags out of the splitter
// no dependencies

interface bls_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [15:0] entry_index;
  logic        is_text;
  logic        done_res;
  logic [1:0]  status;
  logic [15:0] entry_count;

  modport source (output valid, output byte_role, output entry_index, output is_text,
                  output done_res, output status, output entry_count, input ready);
  modport sink   (input valid, input byte_role, input entry_index, input is_text,
                  input done_res, input status, input entry_count, output ready);
endinterface

/* hw/rtl/bracketed_list_splitter_unit.sv */
// bracketed_list_splitter_unit: splits a bracketed, comma separated text into entries
// depends on bls_pkg, bls_in_if, bls_out_if
//
// channel    dir  handshake            payload
// in_chan    in   valid/ready          text_byte, is_final
// out_chan   out  valid/ready          byte_role, entry_index, is_text, done_res,
//                                      status, entry_count
// cfg (apb)  in   psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// one byte per cycle while the output is not stalled: the parse state updates at acceptance and the result
// lands in the output register on the same edge
// a stalled output blocks input only while its register is full and not taken
// rst_n is synchronous; it clears parse state, output valid and the config registers

module bracketed_list_splitter_unit
  import bls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bls_in_if.sink      in_chan,
  bls_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_INSIDE = 2'd1,
    PH_AFTER  = 2'd2,
    PH_REJECT = 2'd3
  } phase_t;

  // configuration
  logic               resize_mode_r;
  logic [COUNT_W-1:0] expected_count_r;
  logic               cfg_wr;
  reg_idx_t           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_sel)
      REG_RESIZE_MODE:    prdata = {31'd0, resize_mode_r};
      REG_EXPECTED_COUNT: prdata = {16'd0, expected_count_r};
      default:            prdata = 32'd0;
    endcase
  end

  // parse state
  phase_t             phase_r, phase_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [COUNT_W-1:0] entry_r, entry_nxt;
  logic               entry_text_r, entry_text_nxt;
  logic               content_text_r, content_text_nxt;
  logic               empty_seen_r, empty_seen_nxt;
  logic               failed_r, failed_nxt;

  // output register
  logic               out_valid_r;
  role_t              role_r, role_nxt;
  logic [COUNT_W-1:0] index_r, index_nxt;
  logic               text_r, text_nxt;
  logic               done_r;
  status_t            status_r, status_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic       in_fire;
  logic [7:0] c;
  logic       ws, opener, closer;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign c             = in_chan.text_byte;
  assign ws            = is_space(c);
  assign opener        = is_opener(c);
  assign closer        = is_closer(c);

  always_comb begin
    phase_nxt        = phase_r;
    depth_nxt        = depth_r;
    entry_nxt        = entry_r;
    entry_text_nxt   = entry_text_r;
    content_text_nxt = content_text_r;
    empty_seen_nxt   = empty_seen_r;
    failed_nxt       = failed_r;
    role_nxt         = ROLE_INVALID;
    index_nxt        = '0;
    text_nxt         = !ws;
    status_nxt       = ST_OK;
    count_nxt        = '0;

    unique case (phase_r)
      PH_BEFORE: begin
        if (ws) begin
          role_nxt = ROLE_SPACE;
        end else if (c == CH_LBRACK) begin
          role_nxt  = ROLE_OPEN;
          phase_nxt = PH_INSIDE;
          depth_nxt = DEPTH_W'(1);
        end else begin
          failed_nxt = 1'b1;
          phase_nxt  = PH_REJECT;
        end
      end
      PH_INSIDE: begin
        index_nxt = entry_r;
        if (closer && depth_r <= DEPTH_W'(1)) begin
          if (content_text_r && !entry_text_r) empty_seen_nxt = 1'b1;
          depth_nxt = '0;
          if (c == CH_RBRACK) begin
            role_nxt  = ROLE_CLOSE;
            phase_nxt = PH_AFTER;
          end else begin
            index_nxt  = '0;
            failed_nxt = 1'b1;
            phase_nxt  = PH_REJECT;
          end
        end else if (c == CH_COMMA && depth_r == DEPTH_W'(1)) begin
          role_nxt         = ROLE_SEP;
          content_text_nxt = 1'b1;
          if (!entry_text_r) empty_seen_nxt = 1'b1;
          entry_text_nxt = 1'b0;
          if ({1'b0, entry_r} + 17'd1 < {1'b0, ENTRY_CAP}) begin
            entry_nxt = entry_r + COUNT_W'(1);
          end else begin
            failed_nxt = 1'b1;
          end
        end else begin
          role_nxt = ROLE_ENTRY;
          if (opener) begin
            if (depth_r < DEPTH_CAP) depth_nxt = depth_r + DEPTH_W'(1);
            else failed_nxt = 1'b1;
          end else if (closer) begin
            depth_nxt = depth_r - DEPTH_W'(1);
          end
          if (!ws) begin
            entry_text_nxt   = 1'b1;
            content_text_nxt = 1'b1;
          end
        end
      end
      PH_AFTER: begin
        if (ws) begin
          role_nxt = ROLE_SPACE;
        end else begin
          failed_nxt = 1'b1;
          phase_nxt  = PH_REJECT;
        end
      end
      PH_REJECT: begin
        role_nxt = ROLE_INVALID;
      end
      default: begin
        role_nxt = ROLE_INVALID;
      end
    endcase

    if (in_chan.is_final) begin
      count_nxt = content_text_nxt ? entry_nxt + COUNT_W'(1) : '0;
      if (failed_nxt || phase_nxt != PH_AFTER) status_nxt = ST_UNABLE;
      else if (!resize_mode_r && count_nxt != expected_count_r) status_nxt = ST_DOMAIN;
      else if (empty_seen_nxt) status_nxt = ST_UNABLE;
      else status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resize_mode_r    <= 1'b1;
      expected_count_r <= '0;
      phase_r          <= PH_BEFORE;
      depth_r          <= '0;
      entry_r          <= '0;
      entry_text_r     <= 1'b0;
      content_text_r   <= 1'b0;
      empty_seen_r     <= 1'b0;
      failed_r         <= 1'b0;
      out_valid_r      <= 1'b0;
      done_r           <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_sel)
          REG_RESIZE_MODE:    resize_mode_r    <= pwdata[0];
          REG_EXPECTED_COUNT: expected_count_r <= pwdata[COUNT_W-1:0];
          default:            ;
        endcase
      end
      if (in_fire) begin
        if (in_chan.is_final) begin
          // end of text: back to the start state for the next one
          phase_r        <= PH_BEFORE;
          depth_r        <= '0;
          entry_r        <= '0;
          entry_text_r   <= 1'b0;
          content_text_r <= 1'b0;
          empty_seen_r   <= 1'b0;
          failed_r       <= 1'b0;
        end else begin
          phase_r        <= phase_nxt;
          depth_r        <= depth_nxt;
          entry_r        <= entry_nxt;
          entry_text_r   <= entry_text_nxt;
          content_text_r <= content_text_nxt;
          empty_seen_r   <= empty_seen_nxt;
          failed_r       <= failed_nxt;
        end
        out_valid_r <= 1'b1;
        done_r      <= in_chan.is_final;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      role_r   <= role_nxt;
      index_r  <= index_nxt;
      text_r   <= text_nxt;
      status_r <= status_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.byte_role   = role_r;
  assign out_chan.entry_index = index_r;
  assign out_chan.is_text     = text_r;
  assign out_chan.done_res    = done_r;
  assign out_chan.status      = status_r;
  assign out_chan.entry_count = count_r;

  // final byte always leaves the parser in its start state
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.is_final |=> phase_r == PH_BEFORE && depth_r == '0 && entry_r == '0)
    else $error("parse state not cleared after final byte");

  // inside the list the outer bracket is always counted
  a_inside_depth: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_INSIDE |-> depth_r != '0)
    else $error("zero depth while inside list");

  // status and count only on the final result
  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> status_r == ST_OK && count_r == '0)
    else $error("status reported on non-final result");

  // input only stalls behind a full, untaken output register
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_valid_r && !out_chan.ready)
    else $error("input stalled without output backpressure");

endmodule
